// ===== design/delta_list_timer_queue_defines.svh =====
// Assertion macros shared by the timer queue checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef DELTA_LIST_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DLTQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DLTQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dltq_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// delta-list timer queue. No dependencies.
`default_nettype none

package dltq_pkg;

   localparam int POOL_SLOTS_DEFAULT = 16;

   localparam int DELAY_W  = 32;
   localparam int ID_W     = 8;
   localparam int ARG_W    = 32;
   localparam int TICK_W   = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;

   localparam int REQ_FIELDS_W = DELAY_W + ID_W + ARG_W + TICK_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = SLOT_W + ID_W + ARG_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   localparam logic CMD_TICK     = 1'b0;
   localparam logic CMD_REGISTER = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_REGISTERED = 2'd0,
      ST_FULL       = 2'd1,
      ST_EXPIRED    = 2'd2
   } status_type;

   // which slot index drives the memory read port
   typedef enum logic [1:0] {
      SEL_FREE,
      SEL_HEAD,
      SEL_LINK
   } rd_sel_type;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       set_slot;
      logic       walk_init;
      logic       walk_step;
      logic       walk_stop;
      logic       ins_first;
      logic       ins_second;
      logic       tick_expire;
      logic       tick_reduce;
      logic       rsp_load;
      status_type rsp_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic is_register;
      logic free_empty;
      logic head_empty;
      logic link_nil;
      logic walk_ge;
      logic due;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/dltq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dltq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/dltq_ctrl.sv =====
// Sequencer for the timer queue: dispatch, queue walk, insertion, tick and
// response hand-off. Depends on dltq_pkg.
`default_nettype none

module dltq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire dltq_pkg::dp_status_type sts,
   output dltq_pkg::dp_cmd_type         ctl
);

   import dltq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_FREE,
      S_WALK,
      S_INS_A,
      S_INS_B,
      S_TICK,
      S_RESP
   } state_type;

   state_type  state_ff, state_in;
   status_type kind_ff, kind_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (sts.is_register) begin
               if (sts.free_empty) begin
                  kind_in  = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  ctl.rd_en    = 1'b1;
                  ctl.rd_sel   = SEL_FREE;
                  ctl.set_slot = 1'b1;
                  state_in     = S_FREE;
               end
            end else if (sts.head_empty) begin
               state_in = S_IDLE;
            end else begin
               ctl.rd_en    = 1'b1;
               ctl.rd_sel   = SEL_HEAD;
               ctl.set_slot = 1'b1;
               state_in     = S_TICK;
            end
         end
         S_FREE: begin
            ctl.walk_init = 1'b1;
            if (sts.head_empty) begin
               state_in = S_INS_A;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = SEL_HEAD;
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.walk_ge) begin
               ctl.walk_step = 1'b1;
               if (sts.link_nil) begin
                  state_in = S_INS_A;
               end else begin
                  ctl.rd_en  = 1'b1;
                  ctl.rd_sel = SEL_LINK;
               end
            end else begin
               ctl.walk_stop = 1'b1;
               state_in      = S_INS_A;
            end
         end
         S_INS_A: begin
            ctl.ins_first = 1'b1;
            state_in      = S_INS_B;
         end
         S_INS_B: begin
            ctl.ins_second = 1'b1;
            kind_in        = ST_REGISTERED;
            state_in       = S_RESP;
         end
         S_TICK: begin
            if (sts.due) begin
               ctl.tick_expire = 1'b1;
               kind_in         = ST_EXPIRED;
               state_in        = S_RESP;
            end else begin
               ctl.tick_reduce = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_RESP: begin
            ctl.rsp_kind = kind_ff;
            if (sts.rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= ST_REGISTERED;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/dltq_datapath.sv =====
// Timer queue datapath: slot memories, link valid bits, queue heads, walk
// registers and the response register. Depends on dltq_pkg and dltq_ram.
`default_nettype none

module dltq_datapath #(
   parameter int POOL_SLOTS = dltq_pkg::POOL_SLOTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_cmd,
   input  wire logic [dltq_pkg::DELAY_W-1:0]  in_delay,
   input  wire logic [dltq_pkg::ID_W-1:0]     in_id,
   input  wire logic [dltq_pkg::ARG_W-1:0]    in_arg,
   input  wire logic [dltq_pkg::TICK_W-1:0]   in_tick,
   input  wire dltq_pkg::dp_cmd_type          ctl,
   output dltq_pkg::dp_status_type            sts,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic [dltq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [dltq_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [dltq_pkg::ID_W-1:0]          rsp_id,
   output logic [dltq_pkg::ARG_W-1:0]         rsp_arg
);

   import dltq_pkg::*;

   localparam int IW = $clog2(POOL_SLOTS);
   localparam int LW = $clog2(POOL_SLOTS + 1);
   localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);
   localparam int PW = ID_W + ARG_W;

   // captured item
   logic                cmd_ff;
   logic [DELAY_W-1:0]  delay_ff;
   logic [ID_W-1:0]     id_ff;
   logic [ARG_W-1:0]    arg_ff;
   logic [TICK_W-1:0]   tick_ff;

   // queue state
   logic [LW-1:0]       pend_head_ff;
   logic [LW-1:0]       free_head_ff;
   logic                link_valid_ff [POOL_SLOTS];

   // walk registers
   logic [IW-1:0]       slot_ff;
   logic [LW-1:0]       cur_ff;
   logic [LW-1:0]       prev_ff;
   logic [LW-1:0]       next_free_ff;
   logic [DELAY_W-1:0]  delta_cur_ff;
   logic [IW-1:0]       rd_idx_ff;
   logic                rd_valid_ff;

   // response register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [ARG_W-1:0]    rsp_arg_ff;

   logic [LW-1:0]       rd_addr;
   logic [IW-1:0]       rd_idx;
   logic [DELAY_W-1:0]  delta_q;
   logic [LW-1:0]       link_q;
   logic [PW-1:0]       payload_q;
   logic [LW-1:0]       link_rd;

   logic                delta_we;
   logic [IW-1:0]       delta_wa;
   logic [DELAY_W-1:0]  delta_wd;
   logic                link_we;
   logic [IW-1:0]       link_wa;
   logic [LW-1:0]       link_wd;
   logic [IW+SLOT_W-1:0] slot_ext;

   always_comb begin
      case (ctl.rd_sel)
         SEL_FREE: rd_addr = free_head_ff;
         SEL_HEAD: rd_addr = pend_head_ff;
         SEL_LINK: rd_addr = link_rd;
         default:  rd_addr = pend_head_ff;
      endcase
   end
   assign rd_idx = rd_addr[IW-1:0];

   // link entry never written still holds its place in the reset free chain
   assign link_rd = rd_valid_ff ? link_q : (LW'(rd_idx_ff) + LW'(1));

   always_comb begin
      delta_we = 1'b0;
      delta_wa = slot_ff;
      delta_wd = delay_ff;
      if (ctl.ins_first) begin
         delta_we = 1'b1;
      end else if (ctl.ins_second && (cur_ff != NIL)) begin
         delta_we = 1'b1;
         delta_wa = cur_ff[IW-1:0];
         delta_wd = delta_cur_ff - delay_ff;
      end else if (ctl.tick_reduce) begin
         delta_we = 1'b1;
         delta_wd = delta_q - tick_ff;
      end
   end

   always_comb begin
      link_we = 1'b0;
      link_wa = slot_ff;
      link_wd = cur_ff;
      if (ctl.ins_first) begin
         link_we = 1'b1;
      end else if (ctl.ins_second && (prev_ff != NIL)) begin
         link_we = 1'b1;
         link_wa = prev_ff[IW-1:0];
         link_wd = LW'(slot_ff);
      end else if (ctl.tick_expire) begin
         link_we = 1'b1;
         link_wd = free_head_ff;
      end
   end

   dltq_ram #(.WIDTH(DELAY_W), .DEPTH(POOL_SLOTS)) u_delta_ram (
      .clock   (clock),
      .wr_en   (delta_we),
      .wr_addr (delta_wa),
      .wr_data (delta_wd),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_idx),
      .rd_data (delta_q)
   );

   dltq_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_idx),
      .rd_data (link_q)
   );

   dltq_ram #(.WIDTH(PW), .DEPTH(POOL_SLOTS)) u_payload_ram (
      .clock   (clock),
      .wr_en   (ctl.ins_first),
      .wr_addr (slot_ff),
      .wr_data ({id_ff, arg_ff}),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_idx),
      .rd_data (payload_q)
   );

   assign sts.is_register = (cmd_ff == CMD_REGISTER);
   assign sts.free_empty  = (free_head_ff == NIL);
   assign sts.head_empty  = (pend_head_ff == NIL);
   assign sts.link_nil    = (link_rd == NIL);
   assign sts.walk_ge     = (delay_ff >= delta_q);
   assign sts.due         = (delta_q <= tick_ff);
   assign sts.rsp_free    = !rsp_valid_ff || rsp_tready;

   assign slot_ext = {{SLOT_W{1'b0}}, slot_ff};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_head_ff <= NIL;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < POOL_SLOTS; i++) begin
            link_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (link_we) begin
            link_valid_ff[link_wa] <= 1'b1;
         end
         if (ctl.ins_first) begin
            free_head_ff <= next_free_ff;
            if (prev_ff == NIL) begin
               pend_head_ff <= LW'(slot_ff);
            end
         end
         if (ctl.tick_expire) begin
            pend_head_ff <= link_rd;
            free_head_ff <= LW'(slot_ff);
         end
         if (ctl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= in_cmd;
         delay_ff <= in_delay;
         id_ff    <= in_id;
         arg_ff   <= in_arg;
         tick_ff  <= in_tick;
      end else if (ctl.walk_step) begin
         delay_ff <= delay_ff - delta_q;
      end
      if (ctl.rd_en) begin
         rd_idx_ff   <= rd_idx;
         rd_valid_ff <= link_valid_ff[rd_idx];
      end
      if (ctl.set_slot) begin
         slot_ff <= rd_idx;
      end
      if (ctl.walk_init) begin
         next_free_ff <= link_rd;
         cur_ff       <= pend_head_ff;
         prev_ff      <= NIL;
      end else if (ctl.walk_step) begin
         prev_ff <= cur_ff;
         cur_ff  <= link_rd;
      end
      if (ctl.walk_stop) begin
         delta_cur_ff <= delta_q;
      end
      if (ctl.rsp_load) begin
         rsp_status_ff <= ctl.rsp_kind;
         rsp_slot_ff   <= (ctl.rsp_kind == ST_FULL) ? '0 : slot_ext[SLOT_W-1:0];
         rsp_id_ff     <= (ctl.rsp_kind == ST_EXPIRED) ? payload_q[PW-1:ARG_W] : '0;
         rsp_arg_ff    <= (ctl.rsp_kind == ST_EXPIRED) ? payload_q[ARG_W-1:0] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_id     = rsp_id_ff;
   assign rsp_arg    = rsp_arg_ff;

endmodule

`default_nettype wire

// ===== design/delta_list_timer_queue.sv =====
// Delta-list timer queue: a pool of POOL_SLOTS timer slots kept in expiry
// order, each entry holding its delay relative to the entry in front of it.
// A register item (cmd 1) takes the first free slot, walks the queue from the
// head one entry per clock through the delta and link memories, links the new
// entry in behind any entries due at the same time and answers with status 0
// and the slot, or status 1 if no slot is free. A tick item (cmd 0) takes its
// amount off the head delta; if the head falls due it is unlinked, its slot
// goes to the front of the free chain and an expiry (status 2, slot, handler
// token, argument) is answered. Surplus tick time is dropped and a tick on an
// empty queue, or one that leaves the head pending, gives no result item.
// One item is worked on at a time. A register item passes over up to
// POOL_SLOTS - 1 queued entries before it is linked in, the walk reading one
// entry per cycle from the single read port of each slot memory. The next
// item is taken the cycle after the result is loaded, while that result may
// still wait for rsp_tready. Link words not yet written read as the reset
// free chain through per-slot valid flags, so there is no clearing pass after
// reset.
// Depends on dltq_pkg, dltq_ctrl, dltq_datapath and dltq_ram.
`default_nettype none

module delta_list_timer_queue #(
   parameter int POOL_SLOTS = dltq_pkg::POOL_SLOTS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // delay [31:0], callback_id [39:32], callback_arg [71:40], tick_amount [103:72]
   input  wire logic [dltq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // cmd [0]
   input  wire logic [0:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // slot [3:0], callback_id_res [11:4], callback_arg_res [43:12], zero [47:44]
   output logic [dltq_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // status [1:0]
   output logic [dltq_pkg::STATUS_W-1:0]          rsp_tuser
);

   import dltq_pkg::*;

   localparam int ID_LO   = DELAY_W;
   localparam int ARG_LO  = ID_LO + ID_W;
   localparam int TICK_LO = ARG_LO + ARG_W;

   dp_cmd_type    ctl;
   dp_status_type sts;

   logic [SLOT_W-1:0] rsp_slot;
   logic [ID_W-1:0]   rsp_id;
   logic [ARG_W-1:0]  rsp_arg;

   // sequencer: owns the request handshake
   dltq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   // memories, queue heads and the response register
   dltq_datapath #(.POOL_SLOTS(POOL_SLOTS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_cmd     (req_tuser[0]),
      .in_delay   (req_tdata[DELAY_W-1:0]),
      .in_id      (req_tdata[ARG_LO-1:ID_LO]),
      .in_arg     (req_tdata[TICK_LO-1:ARG_LO]),
      .in_tick    (req_tdata[TICK_LO+TICK_W-1:TICK_LO]),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_tuser),
      .rsp_slot   (rsp_slot),
      .rsp_id     (rsp_id),
      .rsp_arg    (rsp_arg)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_arg, rsp_id, rsp_slot};

endmodule

`default_nettype wire

// ===== design/dltq_checker.sv =====
// Port-level checks for the timer queue, bound to the top level.
// Depends on dltq_pkg and delta_list_timer_queue_defines.svh.
`default_nettype none
`include "delta_list_timer_queue_defines.svh"

module dltq_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [dltq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic [dltq_pkg::STATUS_W-1:0]     rsp_tuser
);

   import dltq_pkg::*;

   // stalled result holds
   `DLTQ_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result item changed while stalled")

   // one item at a time: no accept straight after an accept
   `DLTQ_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "input accepted while busy")

   // only expiries carry handler and argument; padding stays zero
   `DLTQ_ASSERT_NOW(a_zero_fields, rsp_tvalid && (rsp_tuser != ST_EXPIRED), rsp_tdata[RSP_TDATA_W-1:SLOT_W] == '0, "non-expiry result carries payload")

   // pool full reports slot zero
   `DLTQ_ASSERT_NOW(a_full_slot, rsp_tvalid && (rsp_tuser == ST_FULL), rsp_tdata[SLOT_W-1:0] == '0, "pool full result with slot set")

   // unused status code never shows
   `DLTQ_ASSERT_NOW(a_status_code, rsp_tvalid, (rsp_tuser == ST_REGISTERED) || (rsp_tuser == ST_FULL) || (rsp_tuser == ST_EXPIRED), "undefined result status")

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== dv/delta_list_timer_queue_tb.sv =====
// Self-checking bench for the delta-list timer queue: a directed table and
// then random register/tick items, results checked against a predictor or the table.
// Depends on dltq_pkg and delta_list_timer_queue.
`default_nettype none

module delta_list_timer_queue_tb;
   import dltq_pkg::*;

   localparam int SLOTS = POOL_SLOTS_DEFAULT;
   localparam logic [4:0] NIL = 5'(SLOTS);   // end-of-chain marker

   // one result item as the block should present it
   typedef struct packed {
      status_type  status;
      logic [3:0]  slot;
      logic [7:0]  cb_id;
      logic [31:0] cb_arg;
   } queue_reply;

   // how a directed row is checked
   typedef enum logic [1:0] {
      CHK_MODEL,   // expectation from the predictor
      CHK_NONE,    // no result item may appear
      CHK_FIXED    // expectation typed into the row
   } row_check;

   typedef struct packed {
      logic        cmd;
      logic [31:0] delay;
      logic [7:0]  cb_id;
      logic [31:0] cb_arg;
      logic [31:0] ticks;
      int          repeats;   // same row sent this many times, id and arg stepping
      row_check    check;
      queue_reply  fixed;
   } script_row;

   localparam queue_reply NO_REPLY = '{ST_REGISTERED, 4'd0, 8'd0, 32'd0};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // delay [31:0], callback_id [39:32], callback_arg [71:40], tick_amount [103:72]
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // cmd [0]
   logic [0:0]             req_tuser = CMD_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // slot [3:0], callback_id_res [11:4], callback_arg_res [43:12], zero [47:44]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // status [1:0]
   logic [STATUS_W-1:0]    rsp_tuser;

   int idle_pct = 0;      // chance in a hundred that the sender holds back a cycle
   int stall_pct = 0;     // chance in a hundred that the receiver stalls a cycle
   int fault_count = 0;

   queue_reply awaited_replies[$];

   // predictor's copy of the timer pool
   logic [31:0] due_delta[SLOTS];
   logic [7:0]  due_handler[SLOTS];
   logic [31:0] due_arg[SLOTS];
   logic [4:0]  chain_link[SLOTS];
   logic [4:0]  busy_head;
   logic [4:0]  idle_head;
   int          busy_count;

   delta_list_timer_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Applies one item to the predicted pool; returns 1 when a result item is due.
   function automatic bit advance_timer_queue(input logic cmd, input logic [31:0] delay,
                                              input logic [7:0] cb_id,
                                              input logic [31:0] cb_arg,
                                              input logic [31:0] ticks,
                                              output queue_reply reply);
      logic [4:0]  s;
      logic [4:0]  prev;
      logic [4:0]  cur;
      logic [31:0] left;
      reply = NO_REPLY;
      if (cmd == CMD_REGISTER) begin
         if (idle_head == NIL) begin
            reply.status = ST_FULL;
            return 1'b1;
         end
         s = idle_head;
         idle_head = chain_link[s];
         // walk past every entry due no later than the new one
         prev = NIL;
         cur = busy_head;
         left = delay;
         while (cur != NIL && left >= due_delta[cur]) begin
            left -= due_delta[cur];
            prev = cur;
            cur = chain_link[cur];
         end
         due_delta[s] = left;
         due_handler[s] = cb_id;
         due_arg[s] = cb_arg;
         chain_link[s] = cur;
         if (cur != NIL) due_delta[cur] -= left;
         if (prev != NIL) chain_link[prev] = s;
         else busy_head = s;
         busy_count++;
         reply.status = ST_REGISTERED;
         reply.slot = s[3:0];
         return 1'b1;
      end
      if (busy_head == NIL) return 1'b0;
      s = busy_head;
      if (due_delta[s] > ticks) begin
         due_delta[s] -= ticks;
         return 1'b0;
      end
      // head due: unlink, free the slot at the front, drop surplus ticks
      busy_head = chain_link[s];
      chain_link[s] = idle_head;
      idle_head = s;
      busy_count--;
      reply = '{ST_EXPIRED, s[3:0], due_handler[s], due_arg[s]};
      return 1'b1;
   endfunction

   // Presents one item from a falling edge, waits for it to be taken and
   // records what it should cause. Returns at the next falling edge.
   task automatic drive_item(input logic cmd, input logic [31:0] delay,
                             input logic [7:0] cb_id, input logic [31:0] cb_arg,
                             input logic [31:0] ticks, input row_check check,
                             input queue_reply fixed);
      queue_reply predicted;
      bit         produces;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = {ticks, cb_arg, cb_id, delay};
      do @(posedge clock); while (!req_tready);
      produces = advance_timer_queue(cmd, delay, cb_id, cb_arg, ticks, predicted);
      case (check)
         CHK_MODEL: begin
            if (produces) awaited_replies.push_back(predicted);
         end
         CHK_FIXED: awaited_replies.push_back(fixed);
         default: ;
      endcase
      @(negedge clock);
   endtask

   // receiver readiness, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(0, 99) >= stall_pct);
   end

   // result checker: oldest expectation against each accepted result item
   always @(posedge clock) begin
      queue_reply want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            $error("result item with nothing expected: status %0d, data %h",
                   rsp_tuser, rsp_tdata);
            fault_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               fault_count++;
            end
            if (rsp_tdata[3:0] !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_tdata[3:0]);
               fault_count++;
            end
            if (rsp_tdata[11:4] !== want.cb_id) begin
               $error("callback_id_res: expected %h, got %h", want.cb_id, rsp_tdata[11:4]);
               fault_count++;
            end
            if (rsp_tdata[43:12] !== want.cb_arg) begin
               $error("callback_arg_res: expected %h, got %h",
                      want.cb_arg, rsp_tdata[43:12]);
               fault_count++;
            end
            if (rsp_tdata[47:44] !== 4'd0) begin
               $error("padding: expected 0, got %h", rsp_tdata[47:44]);
               fault_count++;
            end
         end
      end
   end

   initial begin
      script_row   script[13];
      logic        cmd;
      logic [31:0] delay;
      logic [31:0] ticks;
      int          reg_pct;

      // reset state: nothing pending, free chain 0 -> 1 -> ... -> last
      for (int i = 0; i < SLOTS; i++) chain_link[i] = 5'(i + 1);
      busy_head = NIL;
      idle_head = 5'd0;
      busy_count = 0;

      // Directed: empty-queue tick, equal deadlines, zero and extreme delays,
      // zero and extreme ticks, then the pool filled up and overrun.
      script[0]  = '{CMD_TICK, 32'h0000_0009, 8'h5a, 32'h1234_5678, 32'd5, 1,
                     CHK_NONE, NO_REPLY};
      script[1]  = '{CMD_REGISTER, 32'd10, 8'h01, 32'ha5a5_0001, 32'h0, 1,
                     CHK_FIXED, '{ST_REGISTERED, 4'd0, 8'd0, 32'd0}};
      script[2]  = '{CMD_REGISTER, 32'd10, 8'h02, 32'h5a5a_0002, 32'h0, 1,
                     CHK_FIXED, '{ST_REGISTERED, 4'd1, 8'd0, 32'd0}};
      script[3]  = '{CMD_REGISTER, 32'd0, 8'h03, 32'h0000_0003, 32'h0, 1,
                     CHK_FIXED, '{ST_REGISTERED, 4'd2, 8'd0, 32'd0}};
      script[4]  = '{CMD_REGISTER, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 1,
                     CHK_FIXED, '{ST_REGISTERED, 4'd3, 8'd0, 32'd0}};
      script[5]  = '{CMD_REGISTER, 32'd5, 8'h04, 32'h8000_0004, 32'h0, 1,
                     CHK_FIXED, '{ST_REGISTERED, 4'd4, 8'd0, 32'd0}};
      // zero-delay head goes on a zero tick
      script[6]  = '{CMD_TICK, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 32'd0, 1,
                     CHK_FIXED, '{ST_EXPIRED, 4'd2, 8'h03, 32'h0000_0003}};
      script[7]  = '{CMD_TICK, 32'h0, 8'h00, 32'h0, 32'hffff_ffff, 1, CHK_MODEL, NO_REPLY};
      script[8]  = '{CMD_TICK, 32'h0, 8'h00, 32'h0, 32'd3, 1, CHK_MODEL, NO_REPLY};
      script[9]  = '{CMD_TICK, 32'h0, 8'h00, 32'h0, 32'd7, 1, CHK_MODEL, NO_REPLY};
      script[10] = '{CMD_TICK, 32'h0, 8'h00, 32'h0, 32'd0, 1, CHK_MODEL, NO_REPLY};
      // one entry left pending, fifteen more fill the pool
      script[11] = '{CMD_REGISTER, 32'd0, 8'h10, 32'hc0de_0000, 32'h0, 15,
                     CHK_MODEL, NO_REPLY};
      script[12] = '{CMD_REGISTER, 32'd7, 8'h77, 32'h7777_7777, 32'h0, 1,
                     CHK_FIXED, '{ST_FULL, 4'd0, 8'd0, 32'd0}};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[r]) begin
         for (int k = 0; k < script[r].repeats; k++) begin
            drive_item(script[r].cmd, script[r].delay, script[r].cb_id + 8'(k),
                       script[r].cb_arg + 32'(k), script[r].ticks, script[r].check,
                       script[r].fixed);
         end
      end

      // Random part in four idling phases. Registers are favoured while the
      // queue is short and held back when full, so the pool keeps swinging
      // through empty, deep and overrun states.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         repeat (200) begin
            reg_pct = (busy_count < 3) ? 75 : ((busy_count >= 12) ? 35 : 50);
            cmd = ($urandom_range(0, 99) < reg_pct) ? CMD_REGISTER : CMD_TICK;
            // small delays give many equal deadlines
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: delay = $urandom_range(0, 15);
               5, 6:          delay = $urandom_range(0, 60);
               7:             delay = 32'd0;
               8:             delay = $urandom;
               default:       delay = 32'hffff_ffff;
            endcase
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: ticks = $urandom_range(0, 8);
               6:                ticks = 32'd0;
               7:                ticks = $urandom_range(0, 100);
               8:                ticks = $urandom;
               default:          ticks = 32'hffff_ffff;
            endcase
            drive_item(cmd, delay, 8'($urandom), $urandom, ticks, CHK_MODEL, NO_REPLY);
         end
      end
      req_tvalid = 1'b0;

      // drain, then allow a full register walk for any stray result item
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #1600000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
